// ===== rtl/mrrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrm_pkg
// Shared types and constants of the multi-region register map.
// ----------------------------------------------------------------------------
package mrrm_pkg;

    localparam int NUM_REGIONS  = 4;
    localparam int REGION_WORDS = 64;

    // descriptor registers present on the config port
    localparam int DESC_REGS = 4;
    localparam int DESC_NUM  = (NUM_REGIONS < DESC_REGS) ? NUM_REGIONS : DESC_REGS;

    localparam int DATA_W   = 16;
    localparam int ADDR_W   = 16;
    localparam int DESC_W   = 24;
    localparam int COUNT_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam int OFF_W = (REGION_WORDS > 1) ? $clog2(REGION_WORDS) : 1;
    localparam int SEL_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int WIN_W = $clog2(NUM_REGIONS + 1) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // descriptor fields
    localparam int DESC_START_LSB = 0;
    localparam int DESC_SIZE_LSB  = 16;
    localparam int DESC_SIZE_W    = 7;
    localparam int DESC_WR_BIT    = 23;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_DESC0 = 3'd1;

    // access kinds
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        logic                                is_write;
        logic                                matched;
        logic [SEL_W-1:0]                    sel;
        logic [NUM_REGIONS-1:0]              wr_en;
        logic [NUM_REGIONS-1:0][OFF_W-1:0]   offset;
        logic [DATA_W-1:0]                   write_data;
    } mrrm_cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage : mrrm_pkg
`default_nettype wire

// ===== rtl/mrrm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrm_queue
// Short request queue between the classifying front and the storage back.
// ----------------------------------------------------------------------------
module mrrm_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  mrrm_pkg::mrrm_cmd_t     push_data,
    output logic                    full,
    input  wire logic               pop,
    output mrrm_pkg::mrrm_cmd_t     pop_data,
    output logic                    empty
);
    import mrrm_pkg::*;

    mrrm_cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : mrrm_queue
`default_nettype wire

// ===== rtl/mrrm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrm_front
// Holds the window configuration and classifies each access against all
// windows in parallel.
// ----------------------------------------------------------------------------
module mrrm_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mrrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrrm_pkg::DESC_W-1:0]       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              in_func,
    input  wire logic [mrrm_pkg::ADDR_W-1:0]       in_address,
    input  wire logic [mrrm_pkg::DATA_W-1:0]       in_write_data,
    output logic                                   push,
    output mrrm_pkg::mrrm_cmd_t                    push_data,
    input  wire logic                              queue_full
);
    import mrrm_pkg::*;

    logic [COUNT_W-1:0]            count_reg;
    logic [DESC_W-1:0]             desc_reg [DESC_NUM];
    logic [CFG_IDX_W-1:0]          desc_sel;
    logic [NUM_REGIONS-1:0]        hit;
    logic [NUM_REGIONS-1:0][OFF_W-1:0] offset;
    logic [NUM_REGIONS-1:0]        writable;
    logic [SEL_W-1:0]              first_sel;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign push      = in_valid && !queue_full;
    assign desc_sel  = cfg_index - CFG_REGION_DESC0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < DESC_NUM; i++)
            begin
                desc_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_REGION_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (desc_sel < CFG_IDX_W'(DESC_NUM))
            begin
                desc_reg[desc_sel[SEL_W-1:0]] <= cfg_data;
            end
        end
    end

    for (genvar w = 0; w < NUM_REGIONS; w++)
    begin : g_win
        logic [DESC_W-1:0]       desc;
        logic [ADDR_W:0]         diff;
        logic                    in_use;

        if (w < DESC_NUM)
        begin : g_cfg
            assign desc = desc_reg[w];
        end
        else
        begin : g_zero
            assign desc = '0;
        end

        assign in_use = (WIN_W'(w) < WIN_W'(count_reg));
        assign diff   = {1'b0, in_address} - {1'b0, desc[DESC_START_LSB +: ADDR_W]};
        // below start shows up as a borrow; size is checked both raw and saturated
        assign hit[w] = in_use && !diff[ADDR_W]
                     && (diff[ADDR_W-1:0] < ADDR_W'(desc[DESC_SIZE_LSB +: DESC_SIZE_W]))
                     && (diff[ADDR_W-1:0] < ADDR_W'(REGION_WORDS));
        assign offset[w]   = diff[OFF_W-1:0];
        assign writable[w] = desc[DESC_WR_BIT];
    end

    // lowest-numbered hit wins a read
    always_comb
    begin
        first_sel = '0;
        for (int w = NUM_REGIONS - 1; w >= 0; w--)
        begin
            if (hit[w])
            begin
                first_sel = SEL_W'(w);
            end
        end
    end

    always_comb
    begin
        push_data.is_write   = (in_func == FUNC_WRITE);
        push_data.matched    = |hit;
        push_data.sel        = first_sel;
        push_data.wr_en      = (in_func == FUNC_WRITE) ? (hit & writable) : '0;
        push_data.offset     = offset;
        push_data.write_data = in_write_data;
    end

endmodule : mrrm_front
`default_nettype wire

// ===== rtl/mrrm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrrm_back
// Carries out classified requests on the per-window storage banks and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module mrrm_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  mrrm_pkg::mrrm_cmd_t                cmd,
    input  wire logic                          queue_empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [mrrm_pkg::DATA_W-1:0]        out_read_data,
    output logic                               out_matched,
    output logic                               out_stored
);
    import mrrm_pkg::*;

    back_state_t                   state_reg, state_next;
    mrrm_cmd_t                     cmd_reg;
    logic [DATA_W-1:0]             rd_data_reg [NUM_REGIONS];
    logic [NUM_REGIONS-1:0]        rd_vld_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]             read_data_reg, read_data_next;
    logic                          matched_reg, matched_next;
    logic                          stored_reg, stored_next;
    logic                          out_free;
    logic                          load;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty && out_free)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = !queue_empty && out_free;
            end
            BK_READ:
            begin
                load = 1'b1;
            end
            default:
            begin
                pop  = 1'b0;
                load = 1'b0;
            end
        endcase
    end

    // one bank per window; words never written read as zero
    for (genvar b = 0; b < NUM_REGIONS; b++)
    begin : g_bank
        logic [DATA_W-1:0]        mem [REGION_WORDS];
        logic [REGION_WORDS-1:0]  vld_reg;

        always_ff @(posedge clk)
        begin
            if (pop && cmd.wr_en[b])
            begin
                mem[cmd.offset[b]] <= cmd.write_data;
            end
            if (pop)
            begin
                rd_data_reg[b] <= mem[cmd.offset[b]];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg       <= '0;
                rd_vld_reg[b] <= 1'b0;
            end
            else if (pop)
            begin
                rd_vld_reg[b] <= vld_reg[cmd.offset[b]];
                if (cmd.wr_en[b])
                begin
                    vld_reg[cmd.offset[b]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        matched_next   = matched_reg;
        stored_next    = stored_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            matched_next   = cmd_reg.matched;
            stored_next    = |cmd_reg.wr_en;
            if (!cmd_reg.is_write && cmd_reg.matched && rd_vld_reg[cmd_reg.sel])
            begin
                read_data_next = rd_data_reg[cmd_reg.sel];
            end
            else
            begin
                read_data_next = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        matched_reg   <= matched_next;
        stored_reg    <= stored_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_read_data = read_data_reg;
    assign out_matched   = matched_reg;
    assign out_stored    = stored_reg;

endmodule : mrrm_back
`default_nettype wire

// ===== rtl/multi_region_register_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_region_register_map
// Holding register map built from up to four address windows, each with its
// own storage bank.
//
// s_axis carries one access request: tuser is the access kind (0 read,
// 1 write), tdata holds the address and the write data. m_axis returns one
// result per request: tdata is the read word, tuser the matched and stored
// flags. The cfg channel writes the window count (index 0) and the four
// window descriptors (indexes 1 to 4); it is always ready and must only be
// used while no request is in flight.
// A request is checked against all windows in the cycle it is accepted and
// queued (two entries). The storage side pops it while idle and while the
// result register is free or being taken, reads or writes the banks, then
// loads the result register from the registered bank read. It takes no new
// request while it loads the result of the last one.
// Reset clears the configuration and marks every stored word as zero at once.
// While the receiver stalls the result register holds; once the queue fills,
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module multi_region_register_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mrrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mrrm_pkg::DESC_W-1:0]   cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // reg_address, write_data
    input  wire logic                          s_axis_tuser,  // func
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // read_data
    output logic [1:0]                         m_axis_tuser   // matched, stored
);
    import mrrm_pkg::*;

    mrrm_cmd_t  push_data;
    mrrm_cmd_t  pop_data;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;

    mrrm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_func       (s_axis_tuser),
        .in_address    (s_axis_tdata[15:0]),
        .in_write_data (s_axis_tdata[31:16]),
        .push          (push),
        .push_data     (push_data),
        .queue_full    (queue_full)
    );

    mrrm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    mrrm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (pop_data),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_read_data (m_axis_tdata),
        .out_matched   (m_axis_tuser[0]),
        .out_stored    (m_axis_tuser[1])
    );

endmodule : multi_region_register_map
`default_nettype wire
